// ===== rtl/fsqi_pkg.sv =====
// Shared types, constants and IEEE helper functions for the fast inverse
// square root pipeline. Used by every module in rtl/.
// No dependencies.
package fsqi_pkg;

  localparam int unsigned MantW = 53;
  localparam int unsigned ExpW  = 14;

  // Latency of the arithmetic units and of one refinement step
  localparam int unsigned MulLat  = 4;
  localparam int unsigned AddLat  = 4;
  localparam int unsigned StepLat = 3 * MulLat + AddLat + 1;

  localparam logic [31:0] Magic32   = 32'h5f37_5a86;
  localparam logic [63:0] Magic64   = 64'h5fe6_eb50_c7b5_37a9;
  localparam logic [63:0] Half32    = 64'h0000_0000_3f00_0000;
  localparam logic [63:0] Half64    = 64'h3fe0_0000_0000_0000;
  localparam logic [63:0] OneHalf32 = 64'h0000_0000_3fc0_0000;
  localparam logic [63:0] OneHalf64 = 64'h3ff8_0000_0000_0000;
  localparam logic [63:0] DefNan32  = 64'h0000_0000_ffc0_0000;
  localparam logic [63:0] DefNan64  = 64'hfff8_0000_0000_0000;

  // Special-result codes carried down the unit pipelines
  localparam logic [1:0] SpNone = 2'd0;
  localparam logic [1:0] SpZero = 2'd1;
  localparam logic [1:0] SpInf  = 2'd2;
  localparam logic [1:0] SpNan  = 2'd3;

  typedef logic signed [ExpW-1:0] exp_t;

  typedef struct packed {
    logic valid;
    logic kind;
  } ctl_t;

  // Operand in common form: value = mant * 2^(exp - 52)
  typedef struct packed {
    logic                 sign;
    logic                 zero;
    logic                 inf;
    logic                 nan;
    exp_t                 exp;
    logic [MantW-1:0]     mant;
  } unp_t;

  // Split a raw word into sign, exponent and left-aligned significand
  function automatic unp_t unpack(logic kind, logic [63:0] b);
    unp_t u;
    logic e_max;
    logic e_zero;
    logic f_nz;
    if (kind) begin
      u.sign = b[63];
      e_max  = &b[62:52];
      e_zero = ~|b[62:52];
      f_nz   = |b[51:0];
      u.exp  = e_zero ? exp_t'(-1022) : exp_t'({3'b0, b[62:52]}) - exp_t'(1023);
      u.mant = {~e_zero, b[51:0]};
    end else begin
      u.sign = b[31];
      e_max  = &b[30:23];
      e_zero = ~|b[30:23];
      f_nz   = |b[22:0];
      u.exp  = e_zero ? exp_t'(-126) : exp_t'({6'b0, b[30:23]}) - exp_t'(127);
      u.mant = {~e_zero, b[22:0], 29'b0};
    end
    u.zero = ~|u.mant;
    u.inf  = e_max & ~f_nz;
    u.nan  = e_max & f_nz;
    return u;
  endfunction

  // Count leading zeros; 64 for an all-zero word
  function automatic logic [6:0] lzc64(logic [63:0] v);
    logic [6:0] n;
    n = 7'd64;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) n = 7'(63 - i);
    end
    return n;
  endfunction

  // Encode a special result
  function automatic logic [63:0] spec_bits(logic kind, logic [1:0] code, logic sign);
    logic [63:0] r;
    case (code)
      SpNan:   r = kind ? DefNan64 : DefNan32;
      SpInf:   r = kind ? {sign, 11'h7ff, 52'b0} : {32'b0, sign, 8'hff, 23'b0};
      default: r = kind ? {sign, 63'b0} : {32'b0, sign, 31'b0};
    endcase
    return r;
  endfunction

  // Round to nearest even and pack. mant holds the leading one at bit 63
  // (or is zero), exp is the exponent of that bit.
  function automatic logic [63:0] round_pack(logic kind, logic sign, exp_t exp,
                                             logic [63:0] mant, logic sticky);
    logic [63:0] m;
    logic        st;
    logic        denorm;
    logic [6:0]  sh;
    exp_t        emin;
    exp_t        bias;
    exp_t        emaxf;
    exp_t        shd;
    exp_t        eb;
    logic [52:0] kept;
    logic        guard;
    logic        rest;
    logic        inc;
    logic [53:0] rnd;
    logic        carry;
    logic        hid;
    logic [51:0] frac;
    logic [63:0] r;
    emin   = kind ? exp_t'(-1022) : exp_t'(-126);
    bias   = kind ? exp_t'(1023) : exp_t'(127);
    emaxf  = kind ? exp_t'(2047) : exp_t'(255);
    denorm = exp < emin;
    shd    = emin - exp;
    sh     = !denorm ? 7'd0 : (shd > exp_t'(127)) ? 7'd127 : shd[6:0];
    // Denormalize a tiny result, folding lost bits into sticky
    m      = mant >> sh;
    st     = sticky | (|(mant & ((64'd1 << sh) - 64'd1)));
    if (kind) begin
      kept  = m[63:11];
      guard = m[10];
      rest  = (|m[9:0]) | st;
    end else begin
      kept  = {29'b0, m[63:40]};
      guard = m[39];
      rest  = (|m[38:0]) | st;
    end
    inc   = guard & (rest | kept[0]);
    rnd   = {1'b0, kept} + {53'b0, inc};
    carry = kind ? rnd[53] : rnd[24];
    hid   = kind ? rnd[52] : rnd[23];
    frac  = kind ? rnd[51:0] : {29'b0, rnd[22:0]};
    if (carry) begin
      eb   = exp + bias + exp_t'(1);
      frac = '0;
    end else if (denorm) begin
      eb = hid ? exp_t'(1) : exp_t'(0);
    end else begin
      eb = exp + bias;
    end
    if (mant == '0) begin
      r = spec_bits(kind, SpZero, sign);
    end else if (eb >= emaxf) begin
      r = spec_bits(kind, SpInf, sign);
    end else begin
      r = kind ? {sign, eb[10:0], frac} : {32'b0, sign, eb[7:0], frac[22:0]};
    end
    return r;
  endfunction

endpackage

// ===== rtl/fsqi_fmul.sv =====
// Four-stage IEEE multiplier for binary32 (low bits) or binary64, round to
// nearest even. Depends on fsqi_pkg.
module fsqi_fmul (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fsqi_pkg::ctl_t  ctl_i,
  input  logic [63:0]     a_i,
  input  logic [63:0]     b_i,
  output fsqi_pkg::ctl_t  ctl_o,
  output logic [63:0]     res_o
);

  fsqi_pkg::unp_t ua, ub;
  logic [6:0]     lza, lzb;
  logic [1:0]     sp_d;

  fsqi_pkg::ctl_t ctl1_q, ctl2_q, ctl3_q, ctl4_q;
  logic [1:0]     sp1_q, sp2_q, sp3_q;
  logic           sg1_q, sg2_q, sg3_q;
  fsqi_pkg::exp_t e1_q, e2_q, e3_q;
  logic [52:0]    ma1_q, mb1_q;
  logic [51:0]    hh_q;
  logic [52:0]    hl_q, lh_q;
  logic [53:0]    ll_q;
  logic [105:0]   prod;
  logic [63:0]    m3_d, m3_q;
  logic           st3_d, st3_q;
  fsqi_pkg::exp_t e3_d;
  logic [63:0]    res_q;

  // Unpack, classify and normalize subnormal operands
  always_comb begin
    ua  = fsqi_pkg::unpack(ctl_i.kind, a_i);
    ub  = fsqi_pkg::unpack(ctl_i.kind, b_i);
    lza = fsqi_pkg::lzc64({ua.mant, 11'b0});
    lzb = fsqi_pkg::lzc64({ub.mant, 11'b0});
    if (ua.nan || ub.nan || (ua.inf && ub.zero) || (ua.zero && ub.inf)) begin
      sp_d = fsqi_pkg::SpNan;
    end else if (ua.inf || ub.inf) begin
      sp_d = fsqi_pkg::SpInf;
    end else if (ua.zero || ub.zero) begin
      sp_d = fsqi_pkg::SpZero;
    end else begin
      sp_d = fsqi_pkg::SpNone;
    end
  end

  // Form the product in three steps: partials, sum, normalize
  always_comb begin
    prod = {hh_q, 54'b0} + {26'b0, hl_q, 27'b0} + {26'b0, lh_q, 27'b0} + {52'b0, ll_q};
    if (prod[105]) begin
      m3_d  = prod[105:42];
      st3_d = |prod[41:0];
      e3_d  = e2_q + fsqi_pkg::exp_t'(1);
    end else begin
      m3_d  = prod[104:41];
      st3_d = |prod[40:0];
      e3_d  = e2_q;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
      ctl4_q <= '0;
    end else begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
      ctl4_q <= ctl3_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    sp1_q  <= sp_d;
    sg1_q  <= ua.sign ^ ub.sign;
    ma1_q  <= ua.mant << lza[5:0];
    mb1_q  <= ub.mant << lzb[5:0];
    e1_q   <= (ua.exp - fsqi_pkg::exp_t'({7'b0, lza})) +
              (ub.exp - fsqi_pkg::exp_t'({7'b0, lzb}));
    sp2_q  <= sp1_q;
    sg2_q  <= sg1_q;
    e2_q   <= e1_q;
    hh_q   <= ma1_q[52:27] * mb1_q[52:27];
    hl_q   <= ma1_q[52:27] * mb1_q[26:0];
    lh_q   <= ma1_q[26:0] * mb1_q[52:27];
    ll_q   <= ma1_q[26:0] * mb1_q[26:0];
    sp3_q  <= sp2_q;
    sg3_q  <= sg2_q;
    e3_q   <= e3_d;
    m3_q   <= m3_d;
    st3_q  <= st3_d;
    res_q  <= (sp3_q == fsqi_pkg::SpNone) ?
              fsqi_pkg::round_pack(ctl3_q.kind, sg3_q, e3_q, m3_q, st3_q) :
              fsqi_pkg::spec_bits(ctl3_q.kind, sp3_q, sg3_q);
  end

  assign ctl_o = ctl4_q;
  assign res_o = res_q;

endmodule

// ===== rtl/fsqi_fadd.sv =====
// Four-stage IEEE adder for binary32 (low bits) or binary64, round to
// nearest even. Depends on fsqi_pkg.
module fsqi_fadd (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fsqi_pkg::ctl_t  ctl_i,
  input  logic [63:0]     a_i,
  input  logic [63:0]     b_i,
  output fsqi_pkg::ctl_t  ctl_o,
  output logic [63:0]     res_o
);

  fsqi_pkg::unp_t ua, ub;
  logic           a_big;
  fsqi_pkg::exp_t diff;
  logic [1:0]     sp_d;

  fsqi_pkg::ctl_t ctl1_q, ctl2_q, ctl3_q, ctl4_q;
  logic [1:0]     sp1_q, sp2_q, sp3_q;
  logic           isg1_q, isg2_q, isg3_q;
  logic           zsg1_q, zsg2_q;
  logic           sgn1_q, sgn2_q, sgn3_q;
  logic           sub1_q;
  logic [6:0]     d1_q;
  logic [52:0]    mbg1_q, msm1_q;
  fsqi_pkg::exp_t e1_q, e2_q, e3_q;
  logic [55:0]    aln_full, aln;
  logic [56:0]    sum_d, sum2_q;
  logic [6:0]     lz;
  logic [63:0]    m3_q;
  logic [63:0]    res_q;

  // Unpack, classify and order by magnitude
  always_comb begin
    ua    = fsqi_pkg::unpack(ctl_i.kind, a_i);
    ub    = fsqi_pkg::unpack(ctl_i.kind, b_i);
    a_big = (ua.exp > ub.exp) || ((ua.exp == ub.exp) && (ua.mant >= ub.mant));
    diff  = a_big ? (ua.exp - ub.exp) : (ub.exp - ua.exp);
    if (ua.nan || ub.nan || (ua.inf && ub.inf && (ua.sign != ub.sign))) begin
      sp_d = fsqi_pkg::SpNan;
    end else if (ua.inf || ub.inf) begin
      sp_d = fsqi_pkg::SpInf;
    end else begin
      sp_d = fsqi_pkg::SpNone;
    end
  end

  // Align the smaller operand with sticky, then add or subtract
  always_comb begin
    aln_full = {msm1_q, 3'b0};
    aln      = (aln_full >> d1_q) | {55'b0, |(aln_full & ((56'd1 << d1_q) - 56'd1))};
    sum_d    = sub1_q ? ({1'b0, mbg1_q, 3'b0} - {1'b0, aln}) :
                        ({1'b0, mbg1_q, 3'b0} + {1'b0, aln});
    lz       = fsqi_pkg::lzc64({sum2_q, 7'b0});
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
      ctl4_q <= '0;
    end else begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
      ctl4_q <= ctl3_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    sp1_q  <= sp_d;
    isg1_q <= ua.inf ? ua.sign : ub.sign;
    zsg1_q <= ua.sign & ub.sign;
    sgn1_q <= a_big ? ua.sign : ub.sign;
    sub1_q <= ua.sign ^ ub.sign;
    d1_q   <= (diff > fsqi_pkg::exp_t'(127)) ? 7'd127 : diff[6:0];
    mbg1_q <= a_big ? ua.mant : ub.mant;
    msm1_q <= a_big ? ub.mant : ua.mant;
    e1_q   <= a_big ? ua.exp : ub.exp;
    sp2_q  <= sp1_q;
    isg2_q <= isg1_q;
    zsg2_q <= zsg1_q;
    sgn2_q <= sgn1_q;
    e2_q   <= e1_q;
    sum2_q <= sum_d;
    sp3_q  <= sp2_q;
    isg3_q <= isg2_q;
    sgn3_q <= (sum2_q == '0) ? zsg2_q : sgn2_q;
    e3_q   <= e2_q + fsqi_pkg::exp_t'(1) - fsqi_pkg::exp_t'({7'b0, lz});
    m3_q   <= {sum2_q, 7'b0} << lz;
    case (sp3_q)
      fsqi_pkg::SpNone: res_q <= fsqi_pkg::round_pack(ctl3_q.kind, sgn3_q, e3_q, m3_q, 1'b0);
      default:          res_q <= fsqi_pkg::spec_bits(ctl3_q.kind, sp3_q, isg3_q);
    endcase
  end

  assign ctl_o = ctl4_q;
  assign res_o = res_q;

endmodule

// ===== rtl/fsqi_newton.sv =====
// One Newton step y * (1.5 - (xh * y) * y) built from three multipliers and
// one adder in series. Depends on fsqi_pkg, fsqi_fmul, fsqi_fadd.
module fsqi_newton (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fsqi_pkg::ctl_t  ctl_i,
  input  logic            en_i,
  input  logic [63:0]     xh_i,
  input  logic [63:0]     y_i,
  output fsqi_pkg::ctl_t  ctl_o,
  output logic [63:0]     y_o
);

  localparam int unsigned DlyN  = fsqi_pkg::StepLat - 1;
  localparam int unsigned TapM2 = fsqi_pkg::MulLat - 1;
  localparam int unsigned TapM3 = 2 * fsqi_pkg::MulLat + fsqi_pkg::AddLat - 1;

  logic [63:0]    ydly_q [DlyN];
  logic [DlyN-1:0] en_q;
  fsqi_pkg::ctl_t c1, c2, c3, c4, ctl_q;
  logic [63:0]    t1, t2, t2n, half15, t3, t4, y_q;

  // Carry y and the enable alongside the arithmetic
  always_ff @(posedge clk_i) begin
    ydly_q[0] <= y_i;
    for (int i = 1; i < DlyN; i++) begin
      ydly_q[i] <= ydly_q[i-1];
    end
    en_q <= {en_q[DlyN-2:0], en_i};
  end

  fsqi_fmul u_mul_a (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctl_i(ctl_i), .a_i(xh_i), .b_i(y_i),
    .ctl_o(c1), .res_o(t1)
  );

  fsqi_fmul u_mul_b (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctl_i(c1), .a_i(t1), .b_i(ydly_q[TapM2]),
    .ctl_o(c2), .res_o(t2)
  );

  // Negate t for 1.5 - t
  assign t2n    = c2.kind ? {~t2[63], t2[62:0]} : {t2[63:32], ~t2[31], t2[30:0]};
  assign half15 = c2.kind ? fsqi_pkg::OneHalf64 : fsqi_pkg::OneHalf32;

  fsqi_fadd u_add (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctl_i(c2), .a_i(half15), .b_i(t2n),
    .ctl_o(c3), .res_o(t3)
  );

  fsqi_fmul u_mul_c (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctl_i(c3), .a_i(ydly_q[TapM3]), .b_i(t3),
    .ctl_o(c4), .res_o(t4)
  );

  // Register the step result; a disabled step passes y unchanged
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= c4;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q <= en_q[DlyN-1] ? t4 : ydly_q[DlyN-1];
  end

  assign ctl_o = ctl_q;
  assign y_o   = y_q;

endmodule

// ===== rtl/fast_sqrt_inverse_newton.sv =====
// Throughput: one word per cycle; busy stays low, as the pipeline (input
// register, halving multiply, three steps, final multiply, output register)
// never stalls and the receiver cannot stall.
// Reset clears all valid bits asynchronously; payload registers are not reset.
// Depends on fsqi_pkg, fsqi_fmul, fsqi_newton.
module fast_sqrt_inverse_newton (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        kind_i,
  input  logic [63:0] operand_bits_i,
  output logic        root_valid_o,
  output logic [63:0] root_bits_o
);

  localparam int unsigned XDly  = fsqi_pkg::MulLat + 3 * fsqi_pkg::StepLat;
  localparam int unsigned SpDly = XDly + fsqi_pkg::MulLat;
  localparam int unsigned Lat   = SpDly + 2;

  logic           in_acc;
  logic [31:0]    bx32;
  logic           nan_d, le0_d, inf_d;
  logic [63:0]    spres_d, seed_d, x_d;

  fsqi_pkg::ctl_t ctl0_q, ch, cs1, cs2, cs3, cf;
  logic [63:0]    x_q, seed_q;
  logic           sp_q;
  logic [63:0]    spres_q;
  logic [63:0]    sdly_q [fsqi_pkg::MulLat];
  logic [63:0]    xdly_q [XDly];
  logic [64:0]    spdly_q [SpDly];
  logic [63:0]    xhdly_q [2 * fsqi_pkg::StepLat];
  logic [63:0]    xh_dly2, xh_dly3;
  logic [63:0]    xh, y1, y2, y3, r;
  logic           root_valid_q;
  logic [63:0]    root_bits_q;

  assign in_acc = start & ~busy;
  assign busy   = 1'b0;
  assign bx32   = operand_bits_i[31:0];

  // Classify the operand and form the seed
  always_comb begin
    if (kind_i) begin
      nan_d   = (&operand_bits_i[62:52]) & (|operand_bits_i[51:0]);
      inf_d   = (operand_bits_i == 64'h7ff0_0000_0000_0000);
      le0_d   = operand_bits_i[63] | (operand_bits_i[62:0] == '0);
      seed_d  = fsqi_pkg::Magic64 - {1'b0, operand_bits_i[63:1]};
      x_d     = operand_bits_i;
      spres_d = nan_d ? (operand_bits_i | 64'h0008_0000_0000_0000) :
                inf_d ? 64'hfff0_0000_0000_0000 : 64'h0;
    end else begin
      nan_d   = (&bx32[30:23]) & (|bx32[22:0]);
      inf_d   = (bx32 == 32'h7f80_0000);
      le0_d   = bx32[31] | (bx32[30:0] == '0);
      seed_d  = {32'b0, fsqi_pkg::Magic32 - {1'b0, bx32[31:1]}};
      x_d     = {32'b0, bx32};
      spres_d = nan_d ? {32'b0, bx32 | 32'h0040_0000} :
                inf_d ? 64'h0000_0000_7f80_0000 : 64'h0;
    end
  end

  // Take a word in
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl0_q <= '0;
    end else begin
      ctl0_q <= '{valid: in_acc, kind: kind_i};
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    seed_q  <= seed_d;
    sp_q    <= nan_d | le0_d | inf_d;
    spres_q <= spres_d;
  end

  // Delay lines for seed, operand and special result
  always_ff @(posedge clk_i) begin
    sdly_q[0]  <= seed_q;
    xdly_q[0]  <= x_q;
    spdly_q[0] <= {sp_q, spres_q};
    for (int i = 1; i < int'(fsqi_pkg::MulLat); i++) begin
      sdly_q[i] <= sdly_q[i-1];
    end
    for (int i = 1; i < int'(XDly); i++) begin
      xdly_q[i] <= xdly_q[i-1];
    end
    for (int i = 1; i < int'(SpDly); i++) begin
      spdly_q[i] <= spdly_q[i-1];
    end
  end

  fsqi_fmul u_half (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctl_i(ctl0_q), .a_i(x_q),
    .b_i(ctl0_q.kind ? fsqi_pkg::Half64 : fsqi_pkg::Half32),
    .ctl_o(ch), .res_o(xh)
  );

  fsqi_newton u_step1 (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctl_i(ch), .en_i(1'b1),
    .xh_i(xh), .y_i(sdly_q[fsqi_pkg::MulLat-1]), .ctl_o(cs1), .y_o(y1)
  );

  fsqi_newton u_step2 (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctl_i(cs1), .en_i(1'b1),
    .xh_i(xh_dly2), .y_i(y1), .ctl_o(cs2), .y_o(y2)
  );

  fsqi_newton u_step3 (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctl_i(cs2), .en_i(cs2.kind),
    .xh_i(xh_dly3), .y_i(y2), .ctl_o(cs3), .y_o(y3)
  );

  // Delay the half operand for the later steps
  always_ff @(posedge clk_i) begin
    xhdly_q[0] <= xh;
    for (int i = 1; i < int'(2 * fsqi_pkg::StepLat); i++) begin
      xhdly_q[i] <= xhdly_q[i-1];
    end
  end

  assign xh_dly2 = xhdly_q[fsqi_pkg::StepLat-1];
  assign xh_dly3 = xhdly_q[2 * fsqi_pkg::StepLat - 1];

  fsqi_fmul u_final (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctl_i(cs3), .a_i(xdly_q[XDly-1]), .b_i(y3),
    .ctl_o(cf), .res_o(r)
  );

  // Drive the result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_valid_q <= 1'b0;
    end else begin
      root_valid_q <= cf.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    root_bits_q <= spdly_q[SpDly-1][64] ? spdly_q[SpDly-1][63:0] : r;
  end

  assign root_valid_o = root_valid_q;
  assign root_bits_o  = root_bits_q;

`ifndef SYNTHESIS
  logic acc_chk;
  assign acc_chk = in_acc & rst_ni;

  a_strobe_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_valid_o == $past(acc_chk, Lat))
    else $error("result strobe does not match an accepted word");

  a_single_zero_ext: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(acc_chk & ~kind_i, Lat) |-> (root_bits_o[63:32] == 32'h0))
    else $error("single-precision result not zero-extended");

  a_negative_gives_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(acc_chk & kind_i & operand_bits_i[63] & ~(&operand_bits_i[62:52]), Lat)
    |-> (root_bits_o == 64'h0))
    else $error("negative double operand did not give +0");
`endif

endmodule

// ===== verif/tb_fast_sqrt_inverse_newton.sv =====
// Self-checking testbench for fast_sqrt_inverse_newton: directed special values and
// random binary32/binary64 operands, checked bit for bit against an inline predictor.
// Depends on fsqi_pkg and the fast_sqrt_inverse_newton RTL.
module tb_fast_sqrt_inverse_newton;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic KindSingle = 1'b0;
  localparam logic KindDouble = 1'b1;
  localparam logic [31:0] QuietNan32 = 32'hffc0_0000;
  localparam int DrainCycles = 80;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        kind_i = KindSingle;
  logic [63:0] operand_bits_i = '0;
  logic        root_valid_o;
  logic [63:0] root_bits_o;

  logic [63:0] root_queue[$];
  int          fail_count = 0;

  fast_sqrt_inverse_newton u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .operand_bits_i (operand_bits_i),
    .root_valid_o   (root_valid_o),
    .root_bits_o    (root_bits_o)
  );

  always #5 clk_i = ~clk_i;

  // Widen a binary32 word to an exact real value
  function automatic real f32_to_real(logic [31:0] b);
    if (b[30:23] == 8'hff)
      return $bitstoreal({b[31], 11'h7ff, b[22:0] != 0, 51'b0});
    if (b[30:23] == 8'h00) begin
      // subnormal: frac * 2^-149, exact in double
      if (b[31]) return -(real'(b[22:0]) * $bitstoreal(64'h36a0_0000_0000_0000));
      return real'(b[22:0]) * $bitstoreal(64'h36a0_0000_0000_0000);
    end
    return $bitstoreal({b[31], 11'(int'(b[30:23]) - 127 + 1023), b[22:0], 29'b0});
  endfunction

  // Round a real value to binary32, nearest even, with subnormals
  function automatic logic [31:0] real_to_f32(real d);
    logic [63:0] b;
    logic [63:0] mant;
    logic [63:0] kept;
    logic        guard;
    logic        rest;
    int          e;
    int          sh;
    b = $realtobits(d);
    if (b[62:52] == 11'h7ff) begin
      if (b[51:0] != 0) return QuietNan32;
      return {b[63], 8'hff, 23'b0};
    end
    if (b[62:52] == 11'h000) return {b[63], 31'b0};
    e    = int'(b[62:52]) - 1023;
    mant = {11'b0, 1'b1, b[51:0]};
    sh   = (e >= -126) ? 29 : 29 + (-126 - e);
    if (sh > 54) return {b[63], 31'b0};
    kept  = mant >> sh;
    guard = mant[sh-1];
    rest  = |(mant & ((64'd1 << (sh - 1)) - 64'd1));
    if (guard && (rest || kept[0])) kept = kept + 64'd1;
    if (e >= -126) begin
      if (kept[24]) begin
        kept = kept >> 1;
        e++;
      end
      if (e > 127) return {b[63], 8'hff, 23'b0};
      return {b[63], 8'(e + 127), kept[22:0]};
    end
    return {b[63], kept[30:0]};
  endfunction

  function automatic logic [31:0] mul32(logic [31:0] a, logic [31:0] b);
    return real_to_f32(f32_to_real(a) * f32_to_real(b));
  endfunction

  // One refinement step at single precision
  function automatic logic [31:0] refine32(logic [31:0] xh, logic [31:0] y);
    logic [31:0] t;
    t = mul32(mul32(xh, y), y);
    t = real_to_f32(f32_to_real(fsqi_pkg::OneHalf32[31:0]) - f32_to_real(t));
    return mul32(y, t);
  endfunction

  function automatic real refine64(real xh, real y);
    real t;
    t = xh * y;
    t = t * y;
    t = $bitstoreal(fsqi_pkg::OneHalf64) - t;
    return y * t;
  endfunction

  // Expected root word for one operand
  function automatic logic [63:0] predict_root(logic kind, logic [63:0] bits);
    logic [31:0] b32;
    logic [31:0] xh32;
    logic [31:0] y32;
    real         x;
    real         y;
    if (kind == KindSingle) begin
      b32 = bits[31:0];
      if (b32[30:23] == 8'hff && b32[22:0] != 0) return {32'b0, b32 | 32'h0040_0000};
      if (b32[31] || b32[30:0] == 0) return '0;
      xh32 = mul32(fsqi_pkg::Half32[31:0], b32);
      y32  = fsqi_pkg::Magic32 - (b32 >> 1);
      y32  = refine32(xh32, y32);
      y32  = refine32(xh32, y32);
      return {32'b0, mul32(b32, y32)};
    end
    if (bits[62:52] == 11'h7ff && bits[51:0] != 0) return bits | 64'h0008_0000_0000_0000;
    if (bits[63] || bits[62:0] == 0) return '0;
    x = $bitstoreal(bits);
    y = $bitstoreal(fsqi_pkg::Magic64 - (bits >> 1));
    y = refine64($bitstoreal(fsqi_pkg::Half64) * x, y);
    y = refine64($bitstoreal(fsqi_pkg::Half64) * x, y);
    y = refine64($bitstoreal(fsqi_pkg::Half64) * x, y);
    return $realtobits(x * y);
  endfunction

  // Drive one word after a random gap; record its root on acceptance
  task automatic send_word(logic kind, logic [63:0] bits);
    int gap;
    gap = $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      @(negedge clk_i) start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start          <= 1'b1;
    kind_i         <= kind;
    operand_bits_i <= bits;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    root_queue.push_back(predict_root(kind, bits));
  endtask

  // Hold off until every pending root has come back
  task automatic wait_drained();
    @(negedge clk_i) start <= 1'b0;
    while (root_queue.size() > 0) @(posedge clk_i);
  endtask

  // Compare each strobed root with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && root_valid_o) begin
      if (root_queue.size() == 0) begin
        $error("root_bits: unexpected word, actual %h", root_bits_o);
        fail_count++;
      end else begin
        if (root_bits_o !== root_queue[0]) begin
          $error("root_bits: expected %h, actual %h", root_queue[0], root_bits_o);
          fail_count++;
        end
        void'(root_queue.pop_front());
      end
    end
  end

  task automatic test_single_specials();
    logic [31:0] vals[$];
    vals = '{32'h0000_0000, 32'h8000_0000, 32'hff80_0000, 32'h7f80_0000,
             32'h7fc0_0001, 32'h7f80_0001, 32'hffbf_ffff, 32'h0000_0001,
             32'h007f_ffff, 32'h0080_0000, 32'h7f7f_ffff, 32'h3f80_0000,
             32'hc080_0000};
    foreach (vals[i]) send_word(KindSingle, {$urandom(), vals[i]});
  endtask

  task automatic test_double_specials();
    logic [63:0] vals[$];
    vals = '{64'h0, 64'h8000_0000_0000_0000, 64'hfff0_0000_0000_0000,
             64'h7ff0_0000_0000_0000, 64'h7ff0_0000_0000_0001, 64'hfff8_0000_0000_0123,
             64'h0000_0000_0000_0001, 64'h000f_ffff_ffff_ffff, 64'h0010_0000_0000_0000,
             64'h7fef_ffff_ffff_ffff, 64'h4010_0000_0000_0000, 64'hbff0_0000_0000_0000};
    foreach (vals[i]) send_word(KindDouble, vals[i]);
  endtask

  // Mostly positive finite values, with some specials and raw noise
  task automatic test_random_words(int count);
    logic [63:0] bits;
    logic        kind;
    for (int i = 0; i < count; i++) begin
      kind = 1'($urandom_range(0, 1));
      bits = {$urandom(), $urandom()};
      case ($urandom_range(0, 9))
        0: ;
        1: if (kind) bits[62:52] = $urandom_range(0, 1) ? 11'h7ff : 11'h000;
           else bits[30:23] = $urandom_range(0, 1) ? 8'hff : 8'h00;
        default: if (kind) bits[63] = 1'b0; else bits[31] = 1'b0;
      endcase
      send_word(kind, bits);
      if (i == count / 2) wait_drained();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    test_single_specials();
    test_double_specials();
    wait_drained();
    test_random_words(1100);
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // Stop a hung run
  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/fsqi_pkg.sv
rtl/fsqi_fmul.sv
rtl/fsqi_fadd.sv
rtl/fsqi_newton.sv
rtl/fast_sqrt_inverse_newton.sv
verif/tb_fast_sqrt_inverse_newton.sv
